[rtl/core/bts_pkg.sv]
// Shared constants and types for the buzzer tone sequencer.
package bts_pkg;

    // Register file layout
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_CLOCK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS   = 1'd1;

    // Reset values of the registers
    localparam logic [31:0] PWM_CLOCK_RST = 32'd1000000;
    localparam logic [7:0]  TICK_MS_RST   = 8'd1;

    // Operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Serial divider geometry
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int STEP_W     = 6;
    localparam logic [STEP_W-1:0] STEPS_PERIOD = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_TICKS  = 6'd16;

    // Command to the divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    // Status from the divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

[rtl/core/bts_div.sv]
// Shared serial restoring divider, one quotient bit per cycle.
module bts_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bts_pkg::div_req_t              req,
    input  logic [bts_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [bts_pkg::DIVISOR_W-1:0]  divisor,
    output bts_pkg::div_rsp_t              rsp,
    output logic [bts_pkg::DIVIDEND_W-1:0] quotient
);
    import bts_pkg::*;

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;

    // Shift in the next dividend bit and trial-subtract
    assign rem_sh  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge      = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state under reset, payload free-running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/buzzer_tone_sequencer.sv]
// Buzzer tone sequencer top level: request slot, tone timer and output register.
//
//  Channel  Direction  Handshake           Payload
//  cfg      in         cfg_we              cfg_index, cfg_data
//  in       in         in_valid/in_stall   operation, tone_freq_hz, duration_ms
//  out      out        out_valid/out_stall pwm_period, pwm_compare,
//                                          request_accepted, slot_full
//
//  A request, or a tick that starts no tone, writes the output register from idle.
//  A tick that starts a held tone runs the shared serial divider twice:
//  32 steps for the period, then 16 steps for the tick count.
//  One beat in flight at a time; in_stall is high outside idle (divider
//  work, result write) or while the output register is full and stalled.
//  Reset (rst_n low, asynchronous) clears the tone state and loads the
//  registers with 1000000 Hz and 1 ms.
module buzzer_tone_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [15:0]                    tone_freq_hz,
    input  logic [15:0]                    duration_ms,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [15:0]                    pwm_period,
    output logic [15:0]                    pwm_compare,
    output logic                           request_accepted,
    output logic                           slot_full
);
    import bts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_PERIOD,
        ST_DIV_TICKS,
        ST_WRITE
    } state_t;

    state_t      state_reg, state_next;

    logic [31:0] pwm_clock_reg;
    logic [7:0]  tick_ms_reg;

    logic [15:0] remaining_reg, remaining_next;
    logic        held_valid_reg, held_valid_next;
    logic [15:0] held_freq_reg, held_freq_next;
    logic [15:0] held_dur_reg, held_dur_next;
    logic [15:0] period_reg, period_next;
    logic [15:0] compare_reg, compare_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_period_reg, out_period_next;
    logic [15:0] out_compare_reg, out_compare_next;
    logic        out_acc_reg, out_acc_next;
    logic        out_full_reg, out_full_next;

    logic        in_beat;
    logic        out_free;
    logic [7:0]  tick_eff;

    div_req_t                div_req;
    div_rsp_t                div_rsp;
    logic                    div_start;
    logic [STEP_W-1:0]       div_steps;
    logic [DIVIDEND_W-1:0]   div_dividend;
    logic [DIVISOR_W-1:0]    div_divisor;
    logic [DIVIDEND_W-1:0]   div_quotient;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_beat  = in_valid && !in_stall;
    assign tick_eff = (tick_ms_reg == 8'd0) ? 8'd1 : tick_ms_reg;
    assign div_req  = {div_start, div_steps};

    // Select divider operands: period first, then the tick count
    always_comb
    begin
        if (state_reg == ST_DIV_PERIOD)
        begin
            div_dividend = {held_dur_reg, 16'd0};
            div_divisor  = {8'd0, tick_eff};
            div_steps    = STEPS_TICKS;
        end
        else
        begin
            div_dividend = pwm_clock_reg;
            div_divisor  = held_freq_reg;
            div_steps    = STEPS_PERIOD;
        end
    end

    bts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp),
        .quotient (div_quotient)
    );

    // Sequence the tone state and the output register
    always_comb
    begin
        state_next       = state_reg;
        remaining_next   = remaining_reg;
        held_valid_next  = held_valid_reg;
        held_freq_next   = held_freq_reg;
        held_dur_next    = held_dur_reg;
        period_next      = period_reg;
        compare_next     = compare_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_period_next  = out_period_reg;
        out_compare_next = out_compare_reg;
        out_acc_next     = out_acc_reg;
        out_full_next    = out_full_reg;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (operation == OP_REQUEST)
                    begin
                        // Take the request if the slot is empty
                        out_valid_next   = 1'b1;
                        out_period_next  = period_reg;
                        out_compare_next = compare_reg;
                        out_acc_next     = !held_valid_reg;
                        out_full_next    = 1'b1;
                        if (!held_valid_reg)
                        begin
                            held_valid_next = 1'b1;
                            held_freq_next  = tone_freq_hz;
                            held_dur_next   = duration_ms;
                        end
                    end
                    else if (remaining_reg != 16'd0)
                    begin
                        // Count down the running tone
                        remaining_next   = remaining_reg - 16'd1;
                        out_valid_next   = 1'b1;
                        out_period_next  = period_reg;
                        out_compare_next = compare_reg;
                        out_acc_next     = 1'b0;
                        out_full_next    = held_valid_reg;
                    end
                    else if (held_valid_reg)
                    begin
                        // Start the held tone
                        div_start  = 1'b1;
                        state_next = ST_DIV_PERIOD;
                    end
                    else
                    begin
                        // Silence the buzzer
                        compare_next     = 16'd0;
                        out_valid_next   = 1'b1;
                        out_period_next  = period_reg;
                        out_compare_next = 16'd0;
                        out_acc_next     = 1'b0;
                        out_full_next    = 1'b0;
                    end
                end
            end
            ST_DIV_PERIOD:
            begin
                if (div_rsp.done)
                begin
                    period_next  = div_quotient[15:0];
                    compare_next = {1'b0, div_quotient[15:1]};
                    div_start    = 1'b1;
                    state_next   = ST_DIV_TICKS;
                end
            end
            ST_DIV_TICKS:
            begin
                if (div_rsp.done)
                begin
                    remaining_next  = div_quotient[15:0];
                    held_valid_next = 1'b0;
                    state_next      = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_period_next  = period_reg;
                    out_compare_next = compare_reg;
                    out_acc_next     = 1'b0;
                    out_full_next    = held_valid_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, registers and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pwm_clock_reg  <= PWM_CLOCK_RST;
            tick_ms_reg    <= TICK_MS_RST;
            remaining_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_freq_reg  <= '0;
            held_dur_reg   <= '0;
            period_reg     <= '0;
            compare_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            remaining_reg  <= remaining_next;
            held_valid_reg <= held_valid_next;
            held_freq_reg  <= held_freq_next;
            held_dur_reg   <= held_dur_next;
            period_reg     <= period_next;
            compare_reg    <= compare_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PWM_CLOCK: pwm_clock_reg <= cfg_data;
                    CFG_TICK_MS:   tick_ms_reg   <= cfg_data[7:0];
                    default:       pwm_clock_reg <= pwm_clock_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_period_reg  <= out_period_next;
        out_compare_reg <= out_compare_next;
        out_acc_reg     <= out_acc_next;
        out_full_reg    <= out_full_next;
    end

    assign out_valid        = out_valid_reg;
    assign pwm_period       = out_period_reg;
    assign pwm_compare      = out_compare_reg;
    assign request_accepted = out_acc_reg;
    assign slot_full        = out_full_reg;

`ifndef SYNTHESIS
    // Compare is either silent or half the period
    a_compare_half: assert property (@(posedge clk) disable iff (!rst_n)
        (compare_reg == 16'd0) || (compare_reg == {1'b0, period_reg[15:1]}))
        else $error("compare is neither zero nor half the period");

    // An accepted request always leaves the slot full
    a_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_acc_reg) |-> out_full_reg)
        else $error("accepted request reported with empty slot");

    // Divider works and finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (div_rsp.busy || div_rsp.done)
        |-> ((state_reg == ST_DIV_PERIOD) || (state_reg == ST_DIV_TICKS)))
        else $error("divider active outside a divide state");

    // Starting a tone empties the slot
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_TICKS && div_rsp.done) |=> !held_valid_reg)
        else $error("slot still full after tone start");
`endif

endmodule
